// ----- rtl/core/gap_pkg.sv -----
`default_nettype none

package gap_pkg;

    localparam int CORD_STEPS = 30;
    localparam int CORD_W     = 36;
    localparam int ANG_W      = 34;
    localparam int MUL_W      = 33;
    localparam int PROD_W     = 66;
    localparam int DIV_NW     = 58;
    localparam int DIV_DW     = 31;
    localparam int SQ_RW      = 62;
    localparam int SQ_QW      = 31;

    localparam logic signed [CORD_W-1:0] CORD_GAIN    = 36'sd652032874;
    localparam logic signed [ANG_W-1:0]  HALF_TURN    = 34'sd2147483648;
    localparam logic signed [ANG_W-1:0]  QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [MUL_W-1:0]  INV_TWO_PI   = 33'sd683565276;

    typedef struct packed {
        logic start;
        logic vec;
    } cord_cmd_t;

    // arctan(2^-i) in binary turns, 2^32 per turn
    function automatic logic [29:0] atan_turn(input logic [4:0] i);
        logic [29:0] v;
        unique case (i)
            5'd0:  v = 30'h20000000;
            5'd1:  v = 30'h12E4051E;
            5'd2:  v = 30'h09FB385B;
            5'd3:  v = 30'h051111D4;
            5'd4:  v = 30'h028B0D43;
            5'd5:  v = 30'h0145D7E1;
            5'd6:  v = 30'h00A2F61E;
            5'd7:  v = 30'h00517C55;
            5'd8:  v = 30'h0028BE53;
            5'd9:  v = 30'h00145F2F;
            5'd10: v = 30'h000A2F98;
            5'd11: v = 30'h000517CC;
            5'd12: v = 30'h00028BE6;
            5'd13: v = 30'h000145F3;
            5'd14: v = 30'h0000A2FA;
            5'd15: v = 30'h0000517D;
            5'd16: v = 30'h000028BE;
            5'd17: v = 30'h0000145F;
            5'd18: v = 30'h00000A30;
            5'd19: v = 30'h00000518;
            5'd20: v = 30'h0000028C;
            5'd21: v = 30'h00000146;
            5'd22: v = 30'h000000A3;
            5'd23: v = 30'h00000051;
            5'd24: v = 30'h00000029;
            5'd25: v = 30'h00000014;
            5'd26: v = 30'h0000000A;
            5'd27: v = 30'h00000005;
            5'd28: v = 30'h00000003;
            5'd29: v = 30'h00000001;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/gap_cordic.sv -----
`default_nettype none

module gap_cordic (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire gap_pkg::cord_cmd_t               cmd,
    input  wire logic signed [gap_pkg::CORD_W-1:0] x_in,
    input  wire logic signed [gap_pkg::CORD_W-1:0] y_in,
    input  wire logic signed [31:0]               z_in,
    output logic signed [gap_pkg::MUL_W-1:0]      sin_out,
    output logic signed [gap_pkg::MUL_W-1:0]      cos_out,
    output logic signed [gap_pkg::ANG_W-1:0]      ang_out,
    output logic                                  done
);

    logic signed [gap_pkg::CORD_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [gap_pkg::ANG_W-1:0]  z_reg, z_next, zs, atn;
    logic signed [gap_pkg::CORD_W-1:0] xs, ys;
    logic [4:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next, done_reg, done_next;
    logic vec_reg, vec_next, neg_reg, neg_next, zero_reg, zero_next;
    logic ccw;

    always_comb
    begin
        zs  = {{2{z_in[31]}}, z_in};
        xs  = x_reg >>> cnt_reg;
        ys  = y_reg >>> cnt_reg;
        atn = {4'b0, gap_pkg::atan_turn(cnt_reg)};
        ccw = vec_reg ? y_reg[gap_pkg::CORD_W-1] : ~z_reg[gap_pkg::ANG_W-1];
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        vec_next = vec_reg;
        neg_next = neg_reg;
        zero_next = zero_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            vec_next  = cmd.vec;
            neg_next  = 1'b0;
            zero_next = 1'b0;
            if (cmd.vec)
            begin
                zero_next = (x_in == '0) && (y_in == '0);
                if (x_in[gap_pkg::CORD_W-1])
                begin
                    z_next = y_in[gap_pkg::CORD_W-1] ? -gap_pkg::HALF_TURN : gap_pkg::HALF_TURN;
                    x_next = -x_in;
                    y_next = -y_in;
                end
                else
                begin
                    z_next = '0;
                    x_next = x_in;
                    y_next = y_in;
                end
            end
            else
            begin
                x_next = gap_pkg::CORD_GAIN;
                y_next = '0;
                // fold into the right half plane, negate results at the end
                if (zs > gap_pkg::QUARTER_TURN)
                begin
                    z_next   = zs - gap_pkg::HALF_TURN;
                    neg_next = 1'b1;
                end
                else if (zs < -gap_pkg::QUARTER_TURN)
                begin
                    z_next   = zs + gap_pkg::HALF_TURN;
                    neg_next = 1'b1;
                end
                else
                begin
                    z_next = zs;
                end
            end
        end
        else if (busy_reg)
        begin
            if (ccw)
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - atn;
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + atn;
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(gap_pkg::CORD_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        cnt_reg  <= cnt_next;
        vec_reg  <= vec_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end

    assign sin_out = gap_pkg::MUL_W'(neg_reg ? -y_reg : y_reg);
    assign cos_out = gap_pkg::MUL_W'(neg_reg ? -x_reg : x_reg);
    assign ang_out = zero_reg ? '0 : z_reg;
    assign done    = done_reg;

endmodule

`default_nettype wire

// ----- rtl/core/gap_div.sv -----
`default_nettype none

module gap_div (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             start,
    input  wire logic [gap_pkg::DIV_NW-1:0] num,
    input  wire logic [gap_pkg::DIV_DW-1:0] den,
    output logic      [gap_pkg::DIV_NW-1:0] quo,
    output logic                            done
);

    logic [gap_pkg::DIV_NW-1:0] num_reg, num_next;
    logic [gap_pkg::DIV_DW-1:0] den_reg, den_next, rem_reg, rem_next;
    logic [gap_pkg::DIV_DW:0]   trial;
    logic [5:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next, done_reg, done_next;
    logic qbit;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        trial = {rem_reg, num_reg[gap_pkg::DIV_NW-1]};
        qbit  = (trial >= {1'b0, den_reg});
        num_next = num_reg;
        den_next = den_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? gap_pkg::DIV_DW'(trial - {1'b0, den_reg})
                            : gap_pkg::DIV_DW'(trial);
            num_next = {num_reg[gap_pkg::DIV_NW-2:0], qbit};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(gap_pkg::DIV_NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

    assign quo  = num_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// ----- rtl/core/gap_isqrt.sv -----
`default_nettype none

module gap_isqrt (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            start,
    input  wire logic [gap_pkg::SQ_RW-1:0] rad,
    output logic      [gap_pkg::SQ_QW-1:0] root,
    output logic                           done
);

    logic [gap_pkg::SQ_RW-1:0] rad_reg, rad_next;
    logic [gap_pkg::SQ_QW-1:0] root_reg, root_next;
    logic [33:0] rem_reg, rem_next;
    logic [35:0] cur, tst;
    logic [4:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next, done_reg, done_next;

    // two radicand bits per step
    always_comb
    begin
        cur = {rem_reg, rad_reg[gap_pkg::SQ_RW-1 -: 2]};
        tst = {3'b0, root_reg, 2'b01};
        rad_next  = rad_reg;
        root_next = root_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = rad;
            root_next = '0;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[gap_pkg::SQ_RW-3:0], 2'b00};
            if (cur >= tst)
            begin
                rem_next  = 34'(cur - tst);
                root_next = {root_reg[gap_pkg::SQ_QW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = 34'(cur);
                root_next = {root_reg[gap_pkg::SQ_QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(gap_pkg::SQ_QW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// ----- rtl/core/geodesic_arc_point_generator.sv -----
// Arc point generator: each accepted request yields segment_count+1 great-circle
// destination points (a count of zero is taken as one), bearings stepped evenly
// from start_bearing to end_bearing, on a sphere whose radius is set through the
// cfg write port (write only while idle). One request is worked at a time;
// in_stall stays high until the last point has been handed to the output
// register. Setup runs two 58-step divisions and two 30-step CORDIC runs, then
// each point needs a 58-step bearing division, three 30-step runs on the single
// shared CORDIC unit, a 31-step square root and eleven multiply states on one
// shared 33x33 multiplier; the emit state waits while the output is stalled.
`default_nettype none

module geodesic_arc_point_generator #(
    parameter int MAX_SEGMENTS = 63
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                cfg_valid,
    output logic               cfg_ready,
    input  wire logic [22:0]   sphere_radius,
    input  wire                in_valid,
    output logic               in_stall,
    input  wire logic signed [30:0] center_lat,
    input  wire logic signed [31:0] center_lng,
    input  wire logic [27:0]   arc_radius,
    input  wire logic [24:0]   start_bearing,
    input  wire logic [24:0]   end_bearing,
    input  wire logic [5:0]    segment_count,
    input  wire                close_ring,
    output logic               out_valid,
    input  wire                out_stall,
    output logic signed [30:0] point_lat,
    output logic signed [32:0] point_lng,
    output logic [5:0]         point_index,
    output logic               last_point
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_LDIV  = 5'd1;
    localparam logic [4:0] S_LROT  = 5'd2;
    localparam logic [4:0] S_DMUL  = 5'd3;
    localparam logic [4:0] S_DDIV  = 5'd4;
    localparam logic [4:0] S_DROT  = 5'd5;
    localparam logic [4:0] S_BMUL  = 5'd6;
    localparam logic [4:0] S_BSET  = 5'd7;
    localparam logic [4:0] S_PDIV  = 5'd8;
    localparam logic [4:0] S_PROT  = 5'd9;
    localparam logic [4:0] S_M1    = 5'd10;
    localparam logic [4:0] S_M2    = 5'd11;
    localparam logic [4:0] S_M3    = 5'd12;
    localparam logic [4:0] S_M4    = 5'd13;
    localparam logic [4:0] S_M5    = 5'd14;
    localparam logic [4:0] S_M6    = 5'd15;
    localparam logic [4:0] S_SQ    = 5'd16;
    localparam logic [4:0] S_LATAN = 5'd17;
    localparam logic [4:0] S_M7    = 5'd18;
    localparam logic [4:0] S_M8    = 5'd19;
    localparam logic [4:0] S_M9    = 5'd20;
    localparam logic [4:0] S_M10   = 5'd21;
    localparam logic [4:0] S_M11   = 5'd22;
    localparam logic [4:0] S_NATAN = 5'd23;
    localparam logic [4:0] S_EMIT  = 5'd24;

    localparam int MW = gap_pkg::MUL_W;
    localparam int PW = gap_pkg::PROD_W;
    localparam int CW = gap_pkg::CORD_W;
    localparam int AW = gap_pkg::ANG_W;
    localparam int NW = gap_pkg::DIV_NW;
    localparam int DW = gap_pkg::DIV_DW;

    function automatic logic signed [CW-1:0] mul30(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        t = p + 66'sd536870912;
        return CW'(t >>> 30);
    endfunction

    // binary turns to degrees Q23
    function automatic logic signed [AW-1:0] to_deg(input logic signed [AW-1:0] a);
        logic signed [39:0] t;
        t = 40'(a) * 40'sd45 + 40'sd32;
        return AW'(t >>> 6);
    endfunction

    logic [4:0] state_reg, state_next;
    logic entry_reg;
    logic [22:0] earth_reg;

    logic signed [30:0] lat_reg;
    logic signed [31:0] lng_reg;
    logic [27:0] arc_reg;
    logic [24:0] sb_reg, eb_reg;
    logic [5:0]  seg_reg, idx_reg, seg_in;
    logic close_reg;
    logic [22:0] rad_reg;

    logic signed [MW-1:0] sin_lat, cos_lat, sin_d, cos_d, sin_b, cos_b, s_reg;
    logic signed [31:0]   zt_reg;
    logic signed [CW-1:0] acc_reg, tmp_reg, vx_reg, vy_reg;
    logic [gap_pkg::SQ_QW-1:0] c_reg;
    logic signed [30:0] plat_reg, first_lat;
    logic signed [32:0] plng_reg, first_lng;
    logic signed [34:0] b_reg;

    logic signed [MW-1:0] ma, mb;
    logic signed [PW-1:0] prod_reg;

    logic div_start, div_done, sq_start, sq_done, cord_done;
    logic [NW-1:0] div_num, div_quo;
    logic [DW-1:0] div_den, dbear;
    logic [31:0] lat_abs;
    logic [34:0] b_abs;
    logic [gap_pkg::SQ_RW-1:0] sq_rad;
    logic [gap_pkg::SQ_QW-1:0] sq_root;
    gap_pkg::cord_cmd_t cord_cmd;
    logic signed [CW-1:0] cx, cy;
    logic signed [MW-1:0] c_sin, c_cos;
    logic signed [AW-1:0] c_ang;
    logic signed [36:0] s_sum;
    logic signed [25:0] b_step;
    logic out_free, accept;
    logic out_valid_reg;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        if (segment_count == 6'd0)
            seg_in = 6'd1;
        else if (segment_count > 6'(MAX_SEGMENTS))
            seg_in = 6'(MAX_SEGMENTS);
        else
            seg_in = segment_count;
    end

    // divider operands
    always_comb
    begin
        lat_abs = lat_reg[30] ? 32'(-32'(lat_reg)) : 32'(lat_reg);
        b_abs   = b_reg[34] ? 35'(-b_reg) : 35'(b_reg);
        dbear   = DW'(seg_reg) * DW'(45);
        unique case (state_reg)
            S_LDIV:
            begin
                div_num = (NW'(lat_abs) << 6) + NW'(22);
                div_den = DW'(45);
            end
            S_DDIV:
            begin
                div_num = prod_reg[NW-1:0] + NW'({rad_reg, 8'b0} >> 1);
                div_den = {rad_reg, 8'b0};
            end
            default:
            begin
                div_num = (NW'(b_abs) << 13) + NW'(dbear >> 1);
                div_den = dbear;
            end
        endcase
    end

    assign div_start = entry_reg && ((state_reg == S_LDIV) || (state_reg == S_DDIV)
                                     || (state_reg == S_PDIV));
    assign sq_start  = entry_reg && (state_reg == S_SQ);
    assign sq_rad    = gap_pkg::SQ_RW'(66'sh1000000000000000 - prod_reg);

    assign cord_cmd.start = entry_reg && ((state_reg == S_LROT) || (state_reg == S_DROT)
                            || (state_reg == S_PROT) || (state_reg == S_LATAN)
                            || (state_reg == S_NATAN));
    assign cord_cmd.vec   = (state_reg == S_LATAN) || (state_reg == S_NATAN);
    assign cx = (state_reg == S_NATAN) ? vx_reg : CW'({5'b0, c_reg});
    assign cy = (state_reg == S_NATAN) ? vy_reg : CW'(s_reg);

    // shared multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            S_DMUL:  begin ma = MW'({5'b0, arc_reg}); mb = gap_pkg::INV_TWO_PI; end
            S_BMUL:  begin ma = MW'({8'b0, sb_reg});  mb = MW'({27'b0, seg_reg}); end
            S_M1:    begin ma = sin_lat;               mb = cos_d;   end
            S_M2:    begin ma = cos_lat;               mb = sin_d;   end
            S_M4:    begin ma = MW'(tmp_reg);          mb = cos_b;   end
            S_M6:    begin ma = s_reg;                 mb = s_reg;   end
            S_M7:    begin ma = sin_b;                 mb = sin_d;   end
            S_M9:    begin ma = MW'(tmp_reg);          mb = cos_lat; end
            S_M10:   begin ma = sin_lat;               mb = s_reg;   end
            default: begin ma = '0;                    mb = '0;      end
        endcase
    end

    assign s_sum  = 37'(acc_reg) + 37'(mul30(prod_reg));
    assign b_step = $signed({1'b0, eb_reg}) - $signed({1'b0, sb_reg});

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_LDIV;
            S_LDIV:  if (div_done) state_next = S_LROT;
            S_LROT:  if (cord_done) state_next = S_DMUL;
            S_DMUL:  state_next = S_DDIV;
            S_DDIV:  if (div_done) state_next = S_DROT;
            S_DROT:  if (cord_done) state_next = S_BMUL;
            S_BMUL:  state_next = S_BSET;
            S_BSET:  state_next = S_PDIV;
            S_PDIV:  if (div_done) state_next = S_PROT;
            S_PROT:  if (cord_done) state_next = S_M1;
            S_M1:    state_next = S_M2;
            S_M2:    state_next = S_M3;
            S_M3:    state_next = S_M4;
            S_M4:    state_next = S_M5;
            S_M5:    state_next = S_M6;
            S_M6:    state_next = S_SQ;
            S_SQ:    if (sq_done) state_next = S_LATAN;
            S_LATAN: if (cord_done) state_next = S_M7;
            S_M7:    state_next = S_M8;
            S_M8:    state_next = S_M9;
            S_M9:    state_next = S_M10;
            S_M10:   state_next = S_M11;
            S_M11:   state_next = S_NATAN;
            S_NATAN: if (cord_done) state_next = S_EMIT;
            S_EMIT:
            begin
                if (out_free)
                    state_next = (idx_reg == seg_reg) ? S_IDLE : S_PDIV;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            entry_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            earth_reg     <= 23'd6371000;
        end
        else
        begin
            state_reg <= state_next;
            entry_reg <= (state_next != state_reg);
            if (cfg_valid && cfg_ready)
                earth_reg <= sphere_radius;
            if (state_reg == S_EMIT && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(ma) * PW'(mb);
        if (accept)
        begin
            lat_reg   <= center_lat;
            lng_reg   <= center_lng;
            arc_reg   <= arc_radius;
            sb_reg    <= start_bearing;
            eb_reg    <= end_bearing;
            seg_reg   <= seg_in;
            close_reg <= close_ring;
            rad_reg   <= (earth_reg == '0) ? 23'd1 : earth_reg;
        end
        unique case (state_reg)
            S_LDIV:
                if (div_done)
                    zt_reg <= lat_reg[30] ? -div_quo[31:0] : div_quo[31:0];
            S_LROT:
                if (cord_done)
                begin
                    sin_lat <= c_sin;
                    cos_lat <= c_cos;
                end
            S_DDIV:
                if (div_done)
                    zt_reg <= div_quo[31:0];
            S_DROT:
                if (cord_done)
                begin
                    sin_d <= c_sin;
                    cos_d <= c_cos;
                end
            S_BSET:
            begin
                b_reg   <= 35'(prod_reg);
                idx_reg <= '0;
            end
            S_PDIV:
                if (div_done)
                    zt_reg <= b_reg[34] ? -div_quo[31:0] : div_quo[31:0];
            S_PROT:
                if (cord_done)
                begin
                    sin_b <= c_sin;
                    cos_b <= c_cos;
                end
            S_M2:  acc_reg <= mul30(prod_reg);
            S_M3:  tmp_reg <= mul30(prod_reg);
            S_M5:
            begin
                if (s_sum > 37'sd1073741824)
                    s_reg <= 33'sd1073741824;
                else if (s_sum < -37'sd1073741824)
                    s_reg <= -33'sd1073741824;
                else
                    s_reg <= MW'(s_sum);
            end
            S_SQ:
                if (sq_done)
                    c_reg <= sq_root;
            S_LATAN:
                if (cord_done)
                    plat_reg <= 31'(to_deg(c_ang));
            S_M8:  tmp_reg <= mul30(prod_reg);
            S_M10: vy_reg  <= mul30(prod_reg);
            S_M11: vx_reg  <= CW'(cos_d) - mul30(prod_reg);
            S_NATAN:
                if (cord_done)
                    plng_reg <= 33'(AW'(lng_reg) + to_deg(c_ang));
            S_EMIT:
            begin
                if (idx_reg == '0)
                begin
                    first_lat <= plat_reg;
                    first_lng <= plng_reg;
                end
                if (out_free)
                begin
                    if (close_reg && idx_reg == seg_reg)
                    begin
                        point_lat <= first_lat;
                        point_lng <= first_lng;
                    end
                    else
                    begin
                        point_lat <= plat_reg;
                        point_lng <= plng_reg;
                    end
                    point_index <= idx_reg;
                    last_point  <= (idx_reg == seg_reg);
                    idx_reg     <= idx_reg + 6'd1;
                    b_reg       <= b_reg + 35'(b_step);
                end
            end
            default: ;
        endcase
    end

    gap_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .done  (div_done)
    );

    gap_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .rad   (sq_rad),
        .root  (sq_root),
        .done  (sq_done)
    );

    gap_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cord_cmd),
        .x_in    (cx),
        .y_in    (cy),
        .z_in    (zt_reg),
        .sin_out (c_sin),
        .cos_out (c_cos),
        .ang_out (c_ang),
        .done    (cord_done)
    );

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("accepted a word but not busy");

    a_one_unit_start: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({div_start, sq_start, cord_cmd.start}))
        else $error("two shared units started together");

    a_emit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) && out_free |=> out_valid)
        else $error("point not presented after emit");
`endif

endmodule

`default_nettype wire

// ----- dv/geodesic_arc_point_generator_tb.sv -----
`default_nettype none

module geodesic_arc_point_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SEG = 63;
    localparam longint INV_TWO_PI_Q32 = 64'd683565276;
    localparam longint GAIN_INV = 64'd652032874;
    localparam longint ONE_Q30 = 64'sd1 <<< 30;
    localparam longint HALF_T = 64'sd1 <<< 31;
    localparam longint QUARTER_T = 64'sd1 <<< 30;
    localparam longint ATAN_T [30] = '{
        'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
        'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
        'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
        'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
        'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001
    };

    typedef struct {
        logic signed [30:0] lat;
        logic signed [31:0] lng;
        logic [27:0]        arc;
        logic [24:0]        sb;
        logic [24:0]        eb;
        logic [5:0]         seg;
        logic               close;
    } arc_req_t;

    typedef struct {
        logic signed [30:0] lat;
        logic signed [32:0] lng;
        logic [5:0]         idx;
        logic               last;
    } arc_point_t;

    class arc_scoreboard;
        arc_point_t pending_points[$];
        logic [22:0] radius_m;
        int fails;

        function new();
            radius_m = 23'd6371000;
            fails = 0;
        endfunction

        function void report(string msg);
            $display("mismatch: %s", msg);
            fails++;
        endfunction

        function longint wrap32(longint v);
            int t;
            t = int'(v);
            return longint'(t);
        endfunction

        function longint rdiv(longint n, longint d);
            if (n >= 0)
                return (n + d / 2) / d;
            return -((-n + d / 2) / d);
        endfunction

        function longint mul30(longint a, longint b);
            return (a * b + (64'sd1 <<< 29)) >>> 30;
        endfunction

        function void sin_cos(longint z, output longint s, output longint c);
            longint x, y, nx;
            bit flip;
            x = GAIN_INV;
            y = 0;
            flip = 0;
            if (z > QUARTER_T) begin
                z -= HALF_T;
                flip = 1;
            end
            else if (z < -QUARTER_T) begin
                z += HALF_T;
                flip = 1;
            end
            for (int i = 0; i < 30; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i);
                    y = y + (x >>> i);
                    z -= ATAN_T[i];
                end
                else begin
                    nx = x + (y >>> i);
                    y = y - (x >>> i);
                    z += ATAN_T[i];
                end
                x = nx;
            end
            s = flip ? -y : y;
            c = flip ? -x : x;
        endfunction

        function longint atan2t(longint y, longint x);
            longint z, nx;
            z = 0;
            if (x == 0 && y == 0)
                return 0;
            if (x < 0) begin
                z = (y >= 0) ? HALF_T : -HALF_T;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < 30; i++) begin
                if (y >= 0) begin
                    nx = x + (y >>> i);
                    y = y - (x >>> i);
                    z += ATAN_T[i];
                end
                else begin
                    nx = x - (y >>> i);
                    y = y + (x >>> i);
                    z -= ATAN_T[i];
                end
                x = nx;
            end
            return z;
        endfunction

        function longint unsigned isqrt(longint unsigned v);
            longint unsigned r, bitv;
            r = 0;
            bitv = 64'd1 << 62;
            while (bitv > v)
                bitv >>= 2;
            while (bitv != 0) begin
                if (v >= r + bitv) begin
                    v -= r + bitv;
                    r = (r >> 1) + bitv;
                end
                else
                    r >>= 1;
                bitv >>= 2;
            end
            return r;
        endfunction

        function longint to_deg23(longint t);
            return (t * 45 + 32) >>> 6;
        endfunction

        function void note_request(arc_req_t rq);
            longint lat, lng, sbv, ebv, seg, sin_lat, cos_lat, sin_d, cos_d, dt;
            longint sin_b, cos_b, s, c, y, x, plat, plng, b, lat0, lng0;
            longint unsigned r, den, arcv;
            arc_point_t p;
            lat = longint'(rq.lat);
            lng = longint'(rq.lng);
            sbv = longint'(rq.sb);
            ebv = longint'(rq.eb);
            seg = longint'(rq.seg);
            arcv = rq.arc;
            r = (radius_m == 0) ? 1 : radius_m;
            den = r * 256;
            lat0 = 0;
            lng0 = 0;
            if (seg == 0)
                seg = 1;
            if (seg > MAX_SEG)
                seg = MAX_SEG;
            sin_cos(wrap32(rdiv(lat * 64, 45)), sin_lat, cos_lat);
            dt = wrap32(longint'(((arcv * INV_TWO_PI_Q32 + den / 2) / den) & 64'hFFFFFFFF));
            sin_cos(dt, sin_d, cos_d);
            for (longint i = 0; i <= seg; i++) begin
                b = sbv * seg + (ebv - sbv) * i;
                sin_cos(wrap32(rdiv(b * 8192, 45 * seg)), sin_b, cos_b);
                s = mul30(sin_lat, cos_d) + mul30(mul30(cos_lat, sin_d), cos_b);
                if (s > ONE_Q30)
                    s = ONE_Q30;
                if (s < -ONE_Q30)
                    s = -ONE_Q30;
                c = longint'(isqrt(longint'(ONE_Q30 * ONE_Q30 - s * s)));
                plat = to_deg23(atan2t(s, c));
                y = mul30(mul30(sin_b, sin_d), cos_lat);
                x = cos_d - mul30(sin_lat, s);
                plng = lng + to_deg23(atan2t(y, x));
                if (i == 0) begin
                    lat0 = plat;
                    lng0 = plng;
                end
                if (rq.close && i == seg) begin
                    plat = lat0;
                    plng = lng0;
                end
                p.lat = plat[30:0];
                p.lng = plng[32:0];
                p.idx = i[5:0];
                p.last = (i == seg);
                pending_points.push_back(p);
            end
        endfunction

        function void check_point(arc_point_t got);
            arc_point_t w;
            if (pending_points.size() == 0) begin
                report($sformatf("unexpected point idx %0d", got.idx));
                return;
            end
            w = pending_points.pop_front();
            if (got.lat !== w.lat)
                report($sformatf("idx %0d lat %0d want %0d", w.idx, got.lat, w.lat));
            if (got.lng !== w.lng)
                report($sformatf("idx %0d lng %0d want %0d", w.idx, got.lng, w.lng));
            if (got.idx !== w.idx)
                report($sformatf("point_index %0d want %0d", got.idx, w.idx));
            if (got.last !== w.last)
                report($sformatf("idx %0d last_point %0b want %0b", w.idx, got.last, w.last));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [22:0] sphere_radius = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [30:0] center_lat = '0;
    logic signed [31:0] center_lng = '0;
    logic [27:0] arc_radius = '0;
    logic [24:0] start_bearing = '0;
    logic [24:0] end_bearing = '0;
    logic [5:0] segment_count = '0;
    logic close_ring = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [30:0] point_lat;
    logic signed [32:0] point_lng;
    logic [5:0] point_index;
    logic last_point;

    arc_scoreboard sb = new();
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_cycles = 0;

    geodesic_arc_point_generator #(.MAX_SEGMENTS(MAX_SEG)) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .sphere_radius(sphere_radius),
        .in_valid(in_valid), .in_stall(in_stall),
        .center_lat(center_lat), .center_lng(center_lng), .arc_radius(arc_radius),
        .start_bearing(start_bearing), .end_bearing(end_bearing),
        .segment_count(segment_count), .close_ring(close_ring),
        .out_valid(out_valid), .out_stall(out_stall),
        .point_lat(point_lat), .point_lng(point_lng),
        .point_index(point_index), .last_point(last_point)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver backpressure; a long hold-off is counted down here
    always @(posedge clk)
    begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        arc_point_t got;
        if (rst_n && out_valid && !out_stall) begin
            got.lat = point_lat;
            got.lng = point_lng;
            got.idx = point_index;
            got.last = last_point;
            sb.check_point(got);
        end
    end

    task automatic send_req(arc_req_t rq);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        center_lat <= rq.lat;
        center_lng <= rq.lng;
        arc_radius <= rq.arc;
        start_bearing <= rq.sb;
        end_bearing <= rq.eb;
        segment_count <= rq.seg;
        close_ring <= rq.close;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(rq);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_points.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_radius(logic [22:0] v);
        cfg_valid <= 1'b1;
        sphere_radius <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.radius_m = v;
    endtask

    function automatic arc_req_t rand_req();
        arc_req_t rq;
        int pick;
        pick = $urandom_range(99);
        if ($urandom_range(99) < 20) begin
            rq.lat = 31'($urandom);
            rq.lng = $urandom;
            rq.arc = 28'($urandom);
            rq.sb = 25'($urandom);
            rq.eb = 25'($urandom);
        end
        else begin
            rq.lat = 31'($signed($urandom_range(1509949440)) - 32'sd754974720);
            rq.lng = 32'($signed({1'b0, $urandom_range(32'd3019898880)}) - 33'sd1509949440);
            rq.arc = ($urandom_range(3) == 0) ? 28'($urandom) : 28'($urandom_range(1 << 24));
            rq.sb = 25'($urandom_range(23592960));
            rq.eb = 25'($urandom_range(23592960));
        end
        // mostly short arcs, a few long ones
        if (pick < 85)
            rq.seg = 6'($urandom_range(6));
        else if (pick < 96)
            rq.seg = 6'($urandom_range(20, 7));
        else
            rq.seg = 6'($urandom_range(63, 21));
        rq.close = 1'($urandom_range(1));
        return rq;
    endfunction

    function automatic arc_req_t mk(int lat, int lng, int arc, int sbr, int ebr,
                                    int seg, bit cl);
        arc_req_t rq;
        rq.lat = 31'(lat);
        rq.lng = lng;
        rq.arc = 28'(arc);
        rq.sb = 25'(sbr);
        rq.eb = 25'(ebr);
        rq.seg = 6'(seg);
        rq.close = cl;
        return rq;
    endfunction

    initial
    begin
        #(12.0 * 8000000);
        $display("geodesic_arc_point_generator_tb failed");
        $finish;
    end

    initial
    begin
        arc_req_t dir[$];
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir.push_back(mk(0, 0, 1000 * 256, 0, 23592960, 4, 0));
        dir.push_back(mk(754974720, 0, 50000 * 256, 0, 23592960, 8, 1));
        dir.push_back(mk(-754974720, 1509949440, 50000 * 256, 23592960, 0, 3, 0));
        dir.push_back(mk(377487360, -1509949440, 0, 0, 5898240, 2, 0));
        dir.push_back(mk(0, 1509949440, 268435455, 1000, 23592000, 5, 1));
        dir.push_back(mk(100, -100, 256, 11796480, 11796480, 0, 0));
        dir.push_back(mk(-1073741824, 32'h80000000, 1 << 20, 25'h1FFFFFF, 0, 1, 1));
        dir.push_back(mk(1073741823, 32'h7FFFFFFF, 1 << 22, 0, 25'h1FFFFFF, 2, 0));
        dir.push_back(mk(-377487360, 0, 100000 * 256, 5898240, 17694720, 63, 1));
        dir.push_back(mk(0, 0, 2000000 * 256, 0, 23592960, 6, 0));
        dir.push_back(mk(500000000, 700000000, 123456789, 20000000, 3000000, 7, 1));
        dir.push_back(mk(-1, -1, 1, 1, 2, 1, 0));
        foreach (dir[k])
            send_req(dir[k]);
        drain();

        // zero radius is taken as one metre
        write_radius(23'd0);
        send_req(mk(100000000, 0, 256, 0, 23592960, 3, 0));
        send_req(mk(0, 0, 268435455, 0, 11796480, 2, 1));
        drain();
        write_radius(23'h7FFFFF);
        send_req(mk(-300000000, 200000000, 268435455, 0, 23592960, 4, 1));
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  write_radius(23'd6000000); end
                1: begin idle_pct = 77; stall_pct = 0;  write_radius(23'd7000000); end
                2: begin idle_pct = 0;  stall_pct = 77; write_radius(23'd6371000); end
                default: begin
                    idle_pct = 15; stall_pct = 15;
                    write_radius(23'($urandom_range(7000000, 6000000)));
                end
            endcase
            for (int n = 0; n < 25; n++) begin
                if (ph == 2 && n == 5)
                    hold_cycles = 3000;
                if (ph == 3 && n == 10) begin
                    // let the pipeline empty out completely
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (sb.pending_points.size() != 0)
                        @(posedge clk);
                end
                send_req(rand_req());
            end
            stall_pct = (ph == 2) ? 77 : stall_pct;
            drain();
        end

        idle_pct = 0;
        stall_pct = 0;
        drain();
        repeat (300) @(posedge clk);
        if (sb.fails == 0 && sb.pending_points.size() == 0)
            $display("geodesic_arc_point_generator_tb passed");
        else
            $display("geodesic_arc_point_generator_tb failed");
        $finish;
    end

endmodule

`default_nettype wire
